// ----- hdl/fla_pkg.sv -----
// Package with shared constants, types and command structs for the free list allocator.
`timescale 1ns / 1ps
package fla_pkg;

  localparam int MaxRegions = 256;
  localparam int IdxBits    = $clog2(MaxRegions);
  localparam int CntBits    = $clog2(MaxRegions + 1);
  localparam int AddrBits   = 32;

  localparam logic [31:0] PageAdd  = 32'h0000_0fff;
  localparam logic [31:0] PageMask = 32'hffff_f000;

  typedef enum logic [1:0] {
    FUNC_ALLOC      = 2'd0,
    FUNC_ALLOC_PAGE = 2'd1,
    FUNC_FREE       = 2'd2,
    FUNC_NONE       = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_SHL_RD,
    S_SHL_WR,
    S_SHR_RD,
    S_SHR_WR,
    S_DONE
  } state_t;

  // Datapath operations selected by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_IDX_INC,
    OP_IDX_DEC,
    OP_IDX_CNT,
    OP_READ,
    OP_CAPTURE,
    OP_ALLOC_APPLY,
    OP_ALLOC_FAIL,
    OP_MERGE_PREV,
    OP_MERGE_BOTH,
    OP_MERGE_NEXT,
    OP_INSERT,
    OP_DROP
  } op_t;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_LEFT,
    SH_RIGHT
  } shift_t;

  typedef struct packed {
    op_t    op;
    shift_t shift;
    logic   shift_wr;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic idx_at_end;
    logic idx_le_pos;
    logic fit;
    logic past_addr;
    logic prev_adj;
    logic next_adj;
    logic table_full;
    logic zero_len;
  } stat_t;

endpackage

// ----- hdl/free_list_allocator.sv -----
// Top level of the first-fit free list allocator with coalescing.
`timescale 1ns / 1ps
// First-fit allocator over an address-sorted table of up to 256 free regions held in a
// single-port-write, registered-read memory. One transaction is worked at a time: a request
// scans the table entry by entry, reading then checking each one, then a removal or
// insertion moves the later entries one at a time, reading then writing each one. The
// result is held in an output register, and the next transaction is accepted in the cycle
// after the result is loaded, once that register is free.
module free_list_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] req_size,
  input  logic [31:0] req_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] addr_out,
  output logic [31:0] total_free,
  output logic [8:0]  entry_count,
  output logic [8:0]  peak_count,
  output logic [31:0] lost_count,
  output logic [31:0] lost_bytes
);

  fla_pkg::cmd_t  cmd;
  fla_pkg::stat_t st;
  logic idle;
  logic in_fire;
  logic [1:0]  r_status;
  logic [31:0] r_addr, r_total, r_lost_cnt, r_lost_bytes;
  logic [fla_pkg::CntBits-1:0] r_count, r_peak;

  assign in_ready = idle;
  assign in_fire  = in_valid && in_ready;

  fla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .out_busy (out_valid && !out_ready),
    .st       (st),
    .idle     (idle),
    .cmd      (cmd)
  );

  fla_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .func         (func),
    .req_size     (req_size),
    .req_addr     (req_addr),
    .cmd          (cmd),
    .st           (st),
    .r_status     (r_status),
    .r_addr       (r_addr),
    .r_total      (r_total),
    .r_count      (r_count),
    .r_peak       (r_peak),
    .r_lost_cnt   (r_lost_cnt),
    .r_lost_bytes (r_lost_bytes)
  );

  // Output register for the result transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= r_status;
      addr_out    <= r_addr;
      total_free  <= r_total;
      entry_count <= 9'(r_count);
      peak_count  <= 9'(r_peak);
      lost_count  <= r_lost_cnt;
      lost_bytes  <= r_lost_bytes;
    end
  end

endmodule

// ----- hdl/fla_ctrl.sv -----
// Controller state machine that sequences scans, merges and table shifts.
`timescale 1ns / 1ps
module fla_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic          out_busy,
  input  fla_pkg::stat_t st,
  output logic          idle,
  output fla_pkg::cmd_t cmd
);

  fla_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fla_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next   = state;
    cmd.op       = fla_pkg::OP_NONE;
    cmd.shift    = fla_pkg::SH_NONE;
    cmd.shift_wr = 1'b0;
    cmd.out_load = 1'b0;
    idle         = (state == fla_pkg::S_IDLE);
    unique case (state)
      fla_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd.op     = fla_pkg::OP_LOAD;
          state_next = fla_pkg::S_SCAN_RD;
        end
      end
      fla_pkg::S_SCAN_RD: begin
        if (!st.is_alloc && !st.is_free) begin
          state_next = fla_pkg::S_DONE;
        end else if (st.idx_at_end) begin
          if (st.is_alloc) begin
            cmd.op     = fla_pkg::OP_ALLOC_FAIL;
            state_next = fla_pkg::S_DONE;
          end else begin
            cmd.op     = fla_pkg::OP_CAPTURE;
            state_next = fla_pkg::S_DECIDE;
          end
        end else begin
          cmd.op     = fla_pkg::OP_READ;
          state_next = fla_pkg::S_SCAN_CHK;
        end
      end
      fla_pkg::S_SCAN_CHK: begin
        if (st.is_alloc && st.fit) begin
          cmd.op = fla_pkg::OP_ALLOC_APPLY;
          if (st.zero_len) begin
            state_next = fla_pkg::S_SHL_RD;
          end else begin
            state_next = fla_pkg::S_DONE;
          end
        end else if (st.is_free && st.past_addr) begin
          cmd.op     = fla_pkg::OP_CAPTURE;
          state_next = fla_pkg::S_DECIDE;
        end else begin
          cmd.op     = fla_pkg::OP_IDX_INC;
          state_next = fla_pkg::S_SCAN_RD;
        end
      end
      fla_pkg::S_DECIDE: begin
        if (st.prev_adj) begin
          if (st.next_adj) begin
            cmd.op     = fla_pkg::OP_MERGE_BOTH;
            state_next = fla_pkg::S_SHL_RD;
          end else begin
            cmd.op     = fla_pkg::OP_MERGE_PREV;
            state_next = fla_pkg::S_DONE;
          end
        end else if (st.next_adj) begin
          cmd.op     = fla_pkg::OP_MERGE_NEXT;
          state_next = fla_pkg::S_DONE;
        end else if (!st.table_full) begin
          cmd.op     = fla_pkg::OP_IDX_CNT;
          state_next = fla_pkg::S_SHR_RD;
        end else begin
          cmd.op     = fla_pkg::OP_DROP;
          state_next = fla_pkg::S_DONE;
        end
      end
      // Close the gap: entry[idx] <= entry[idx+1] while idx < count.
      fla_pkg::S_SHL_RD: begin
        if (st.idx_at_end) begin
          state_next = fla_pkg::S_DONE;
        end else begin
          cmd.shift  = fla_pkg::SH_LEFT;
          state_next = fla_pkg::S_SHL_WR;
        end
      end
      fla_pkg::S_SHL_WR: begin
        cmd.shift    = fla_pkg::SH_LEFT;
        cmd.shift_wr = 1'b1;
        cmd.op       = fla_pkg::OP_IDX_INC;
        state_next   = fla_pkg::S_SHL_RD;
      end
      // Open a slot: entry[idx] <= entry[idx-1] while idx > pos.
      fla_pkg::S_SHR_RD: begin
        if (st.idx_le_pos) begin
          cmd.op     = fla_pkg::OP_INSERT;
          state_next = fla_pkg::S_DONE;
        end else begin
          cmd.shift  = fla_pkg::SH_RIGHT;
          state_next = fla_pkg::S_SHR_WR;
        end
      end
      fla_pkg::S_SHR_WR: begin
        cmd.shift    = fla_pkg::SH_RIGHT;
        cmd.shift_wr = 1'b1;
        cmd.op       = fla_pkg::OP_IDX_DEC;
        state_next   = fla_pkg::S_SHR_RD;
      end
      fla_pkg::S_DONE: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = fla_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fla_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/fla_dp.sv -----
// Datapath with the region table memory, scan index and statistics registers.
`timescale 1ns / 1ps
module fla_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            func,
  input  logic [31:0]           req_size,
  input  logic [31:0]           req_addr,
  input  fla_pkg::cmd_t         cmd,
  output fla_pkg::stat_t        st,
  output logic [1:0]            r_status,
  output logic [31:0]           r_addr,
  output logic [31:0]           r_total,
  output logic [fla_pkg::CntBits-1:0] r_count,
  output logic [fla_pkg::CntBits-1:0] r_peak,
  output logic [31:0]           r_lost_cnt,
  output logic [31:0]           r_lost_bytes
);

  localparam int IB = fla_pkg::IdxBits;
  localparam int CB = fla_pkg::CntBits;

  // Region table: one entry of start and length.
  logic [63:0] mem [fla_pkg::MaxRegions];
  logic [63:0] rd_data;
  logic [IB-1:0] rd_addr;
  logic          wr_en;
  logic [IB-1:0] wr_addr;
  logic [63:0]   wr_data;

  logic [1:0]  op_func;
  logic [31:0] size;
  logic [31:0] addr;
  logic [CB-1:0] idx;
  logic [CB-1:0] pos;
  logic [CB-1:0] count;
  logic [CB-1:0] peak;
  logic [31:0] total;
  logic [31:0] lost_cnt;
  logic [31:0] lost_bytes;
  logic [1:0]  status;
  logic [31:0] res_addr;
  logic [63:0] cur;
  logic [63:0] prev;
  logic        prev_valid;
  logic        have_next;

  logic [31:0] cur_start, cur_len, prev_start, prev_len, end_addr;
  logic [31:0] page_size;
  logic [CB-1:0] idx_p1, idx_m1;

  assign cur_start  = rd_data[63:32];
  assign cur_len    = rd_data[31:0];
  assign prev_start = prev[63:32];
  assign prev_len   = prev[31:0];
  assign end_addr   = addr + size;
  assign idx_p1     = idx + CB'(1);
  assign idx_m1     = idx - CB'(1);
  assign page_size  = (req_size + fla_pkg::PageAdd) & fla_pkg::PageMask;

  // Read address selection.
  always_comb begin
    unique case (cmd.shift)
      fla_pkg::SH_LEFT:  rd_addr = idx_p1[IB-1:0];
      fla_pkg::SH_RIGHT: rd_addr = idx_m1[IB-1:0];
      default:           rd_addr = idx[IB-1:0];
    endcase
  end

  // Write port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[IB-1:0];
    wr_data = rd_data;
    if (cmd.shift_wr) begin
      wr_en = 1'b1;
    end else begin
      unique case (cmd.op)
        fla_pkg::OP_ALLOC_APPLY: begin
          wr_en   = 1'b1;
          wr_data = {cur_start + size, cur_len - size};
        end
        fla_pkg::OP_MERGE_PREV: begin
          wr_en   = 1'b1;
          wr_addr = idx_m1[IB-1:0];
          wr_data = {prev_start, prev_len + size};
        end
        fla_pkg::OP_MERGE_BOTH: begin
          wr_en   = 1'b1;
          wr_addr = idx_m1[IB-1:0];
          wr_data = {prev_start, prev_len + size + cur[31:0]};
        end
        fla_pkg::OP_MERGE_NEXT: begin
          wr_en   = 1'b1;
          wr_data = {addr, cur[31:0] + size};
        end
        fla_pkg::OP_INSERT: begin
          wr_en   = 1'b1;
          wr_data = {addr, size};
        end
        default: ;
      endcase
    end
  end

  // Table memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Control and statistics registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      pos        <= '0;
      count      <= '0;
      peak       <= '0;
      total      <= '0;
      lost_cnt   <= '0;
      lost_bytes <= '0;
      prev_valid <= 1'b0;
      have_next  <= 1'b0;
      status     <= fla_pkg::ST_OK;
      res_addr   <= '0;
    end else begin
      unique case (cmd.op)
        fla_pkg::OP_LOAD: begin
          op_func    <= func;
          size       <= (func == fla_pkg::FUNC_ALLOC_PAGE) ? page_size : req_size;
          addr       <= req_addr;
          idx        <= '0;
          prev_valid <= 1'b0;
          status     <= fla_pkg::ST_OK;
          res_addr   <= '0;
        end
        fla_pkg::OP_IDX_INC: begin
          idx        <= idx_p1;
          prev       <= rd_data;
          prev_valid <= 1'b1;
        end
        fla_pkg::OP_IDX_DEC: idx <= idx_m1;
        fla_pkg::OP_IDX_CNT: begin
          pos <= idx;
          idx <= count;
        end
        fla_pkg::OP_CAPTURE: begin
          cur       <= rd_data;
          have_next <= (idx != count);
        end
        fla_pkg::OP_ALLOC_APPLY: begin
          res_addr <= cur_start;
          total    <= total - size;
          if (cur_len == size) begin
            count <= count - CB'(1);
          end
        end
        fla_pkg::OP_ALLOC_FAIL: status <= fla_pkg::ST_NOFIT;
        fla_pkg::OP_MERGE_PREV: total <= total + size;
        fla_pkg::OP_MERGE_BOTH: begin
          total <= total + size;
          count <= count - CB'(1);
        end
        fla_pkg::OP_MERGE_NEXT: total <= total + size;
        fla_pkg::OP_INSERT: begin
          total <= total + size;
          count <= count + CB'(1);
          if (count + CB'(1) > peak) begin
            peak <= count + CB'(1);
          end
        end
        fla_pkg::OP_DROP: begin
          status     <= fla_pkg::ST_DROPPED;
          lost_cnt   <= lost_cnt + 32'd1;
          lost_bytes <= lost_bytes + size;
        end
        default: ;
      endcase
    end
  end

  // Status toward the controller.
  assign st.is_alloc   = (op_func == fla_pkg::FUNC_ALLOC) ||
                         (op_func == fla_pkg::FUNC_ALLOC_PAGE);
  assign st.is_free    = (op_func == fla_pkg::FUNC_FREE);
  assign st.idx_at_end = (idx >= count);
  assign st.idx_le_pos = (idx <= pos);
  assign st.fit        = (cur_len >= size);
  assign st.past_addr  = (cur_start > addr);
  assign st.prev_adj   = prev_valid && ((prev_start + prev_len) == addr);
  assign st.next_adj   = have_next && (end_addr == cur[63:32]);
  assign st.table_full = (count == CB'(fla_pkg::MaxRegions));
  assign st.zero_len   = (cur_len == size);

  // Result fields.
  assign r_status     = status;
  assign r_addr       = res_addr;
  assign r_total      = total;
  assign r_count      = count;
  assign r_peak       = peak;
  assign r_lost_cnt   = lost_cnt;
  assign r_lost_bytes = lost_bytes;

endmodule
